### design/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and constants for the cartridge bank mapper: action codes,
// register addresses, bank state and result records.
// ----------------------------------------------------------------------------
package cbm_pkg;

	// extra RAM geometry
	localparam int EXRAM_DEPTH = 1024;
	localparam int EXRAM_AW    = $clog2(EXRAM_DEPTH);

	// bank used by every PRG slot until the first PRG sync
	localparam logic [6:0] LAST_PRG_BANK = 7'd127;

	// register map
	localparam logic [15:0] ADDR_PRG_LAYOUT = 16'h5100;
	localparam logic [15:0] ADDR_CHR_LAYOUT = 16'h5101;
	localparam logic [15:0] ADDR_XRAM_CFG   = 16'h5104;
	localparam logic [15:0] ADDR_PRG_BANK0  = 16'h5114;
	localparam logic [15:0] ADDR_SPR_BANK0  = 16'h5120;
	localparam logic [15:0] ADDR_BG_BANK0   = 16'h5128;
	localparam logic [15:0] ADDR_CHR_UPPER  = 16'h5130;
	localparam logic [15:0] ADDR_IRQ_LINE   = 16'h5203;
	localparam logic [15:0] ADDR_IRQ_STATUS = 16'h5204;
	localparam logic [15:0] ADDR_MUL_LO     = 16'h5205;
	localparam logic [15:0] ADDR_MUL_HI     = 16'h5206;
	localparam logic [15:0] ADDR_EXRAM_BASE = 16'h5C00;

	localparam logic [1:0] XRAM_CFG_RO   = 2'd3;
	localparam logic [7:0] UNMAPPED_BYTE = 8'hFF;

	// PRG slot layouts
	localparam logic [1:0] PRG_LAYOUT_32K    = 2'd0;
	localparam logic [1:0] PRG_LAYOUT_16K    = 2'd1;
	localparam logic [1:0] PRG_LAYOUT_16K_8K = 2'd2;
	localparam logic [1:0] PRG_LAYOUT_8K     = 2'd3;

	// CHR slot layouts
	localparam logic [1:0] CHR_LAYOUT_8K = 2'd0;
	localparam logic [1:0] CHR_LAYOUT_4K = 2'd1;
	localparam logic [1:0] CHR_LAYOUT_2K = 2'd2;
	localparam logic [1:0] CHR_LAYOUT_1K = 2'd3;

	typedef enum logic [2:0] {
		ACT_WRITE = 3'd0,
		ACT_READ  = 3'd1,
		ACT_TICK  = 3'd2,
		ACT_PRG   = 3'd3,
		ACT_CHR   = 3'd4
	} cbm_action_t;

	typedef struct packed {
		cbm_action_t action;
		logic [15:0] address;
		logic [7:0]  wdata;
	} cbm_item_t;

	typedef struct packed {
		logic [22:0] rom_offset;
		logic        irq_flag;
		logic        irq_pulse;
		logic [7:0]  read_data;
	} cbm_result_t;

	typedef struct packed {
		logic [1:0]       prg_layout;
		logic [1:0]       chr_layout;
		logic             prg_mapped;
		logic [3:0][7:0]  prg_bank;
		logic [7:0][9:0]  spr_bank;
		logic [3:0][9:0]  bg_bank;
	} cbm_banks_t;

endpackage

### design/cbm_lookup.sv
// ----------------------------------------------------------------------------
// cbm_lookup
// Translates a CPU or pattern address into a PRG or CHR ROM byte offset from
// the current bank modes and bank registers.
// ----------------------------------------------------------------------------
module cbm_lookup import cbm_pkg::*; (
	input  cbm_banks_t  banks,
	input  logic [15:0] address,
	output logic [22:0] prg_offset,
	output logic [22:0] chr_offset
);

	logic [1:0]  slot;
	logic [6:0]  prg_bank;
	logic [12:0] pat;
	logic [9:0]  chr2_bank;

	assign slot = address[14:13];
	assign pat  = address[12:0];

	// pick the 8 KiB PRG bank for this slot
	always_comb begin
		prg_bank = LAST_PRG_BANK;
		if (banks.prg_mapped) begin
			case (banks.prg_layout)
				PRG_LAYOUT_32K: prg_bank = {banks.prg_bank[3][6:2], slot};
				PRG_LAYOUT_16K: begin
					if (slot[1]) begin
						prg_bank = {banks.prg_bank[3][6:1], slot[0]};
					end else begin
						prg_bank = {banks.prg_bank[1][6:1], slot[0]};
					end
				end
				PRG_LAYOUT_16K_8K: begin
					case (slot)
						2'd0: prg_bank = banks.prg_bank[1][6:0];
						2'd1: prg_bank = banks.prg_bank[2][6:0];
						default: prg_bank = {banks.prg_bank[3][6:1], slot[0]};
					endcase
				end
				default: prg_bank = banks.prg_bank[slot][6:0];
			endcase
		end
	end

	// ROM area starts at 0x8000; below it the offset is zero
	assign prg_offset = address[15] ? {3'b000, prg_bank, address[12:0]} : 23'd0;

	// 2 KiB CHR mode bank select
	always_comb begin
		case (pat[12:11])
			2'd0: chr2_bank = banks.spr_bank[1];
			2'd1: chr2_bank = banks.spr_bank[3];
			2'd2: chr2_bank = banks.bg_bank[1];
			default: chr2_bank = banks.bg_bank[3];
		endcase
	end

	// assemble the CHR offset for the active slot size
	always_comb begin
		case (banks.chr_layout)
			CHR_LAYOUT_8K: chr_offset = {banks.spr_bank[7], pat};
			CHR_LAYOUT_4K: begin
				if (pat[12]) begin
					chr_offset = {1'b0, banks.bg_bank[3], pat[11:0]};
				end else begin
					chr_offset = {1'b0, banks.spr_bank[3], pat[11:0]};
				end
			end
			CHR_LAYOUT_2K: chr_offset = {2'b00, chr2_bank, pat[10:0]};
			default: chr_offset = {3'b000, banks.spr_bank[pat[12:10]], pat[9:0]};
		endcase
	end

endmodule

### design/cbm_exram.sv
// ----------------------------------------------------------------------------
// cbm_exram
// 1 KiB extra RAM with registered read, write-to-read forwarding and a
// clearing sweep after reset.
// ----------------------------------------------------------------------------
module cbm_exram import cbm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [EXRAM_AW-1:0] rd_idx,
	input  logic                wr_en,
	input  logic [EXRAM_AW-1:0] wr_idx,
	input  logic [7:0]          wr_data,
	output logic [7:0]          rd_data,
	output logic                busy
);

	logic [7:0]          mem [EXRAM_DEPTH];
	logic [EXRAM_AW:0]   clr_cnt_q;
	logic                mem_we;
	logic [EXRAM_AW-1:0] mem_idx;
	logic [7:0]          mem_wdata;

	assign busy = !clr_cnt_q[EXRAM_AW];

	// sweep one entry per cycle until the counter reaches the depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (busy) begin
			clr_cnt_q <= clr_cnt_q + (EXRAM_AW + 1)'(1);
		end
	end

	// clearing sweep owns the write port while busy
	always_comb begin
		if (busy) begin
			mem_we    = 1'b1;
			mem_idx   = clr_cnt_q[EXRAM_AW-1:0];
			mem_wdata = 8'h00;
		end else begin
			mem_we    = wr_en;
			mem_idx   = wr_idx;
			mem_wdata = wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_idx] <= mem_wdata;
		end
	end

	// registered read; forward a write landing on the same edge
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && wr_idx == rd_idx) begin
				rd_data <= wr_data;
			end else begin
				rd_data <= mem[rd_idx];
			end
		end
	end

endmodule

### design/cbm_ctrl.sv
// ----------------------------------------------------------------------------
// cbm_ctrl
// Mapper register file: bus write and read decode, scanline IRQ counter,
// multiplier and ROM lookups. State advances when an item commits.
// ----------------------------------------------------------------------------
module cbm_ctrl import cbm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                commit,
	input  cbm_item_t           item,
	input  logic [7:0]          ram_rdata,
	output logic                ram_we,
	output logic [EXRAM_AW-1:0] ram_idx,
	output logic [7:0]          ram_wdata,
	output cbm_result_t         result
);

	logic [1:0]      prg_layout_q, chr_layout_q, chr_upper_q, xram_cfg_q;
	logic [3:0][7:0] prg_bank_q;
	logic [7:0][9:0] spr_bank_q;
	logic [3:0][9:0] bg_bank_q;
	logic [7:0]      factor_a_q, factor_b_q, line_cnt_q, line_reload_q;
	logic            irq_en_q, irq_wait_q, prg_mapped_q;

	logic [1:0]      prg_layout_d, chr_layout_d, chr_upper_d, xram_cfg_d;
	logic [3:0][7:0] prg_bank_d;
	logic [7:0][9:0] spr_bank_d;
	logic [3:0][9:0] bg_bank_d;
	logic [7:0]      factor_a_d, factor_b_d, line_cnt_d, line_reload_d;
	logic            irq_en_d, irq_wait_d, prg_mapped_d;

	cbm_banks_t  banks;
	logic [22:0] prg_offset, chr_offset;
	logic [15:0] product;
	logic        in_ram, in_prg_bank, in_spr_bank, in_bg_bank;

	assign banks.prg_layout = prg_layout_q;
	assign banks.chr_layout = chr_layout_q;
	assign banks.prg_mapped = prg_mapped_q;
	assign banks.prg_bank   = prg_bank_q;
	assign banks.spr_bank   = spr_bank_q;
	assign banks.bg_bank    = bg_bank_q;

	cbm_lookup u_lookup (
		.banks      (banks),
		.address    (item.address),
		.prg_offset (prg_offset),
		.chr_offset (chr_offset)
	);

	assign product = {8'h00, factor_a_q} * {8'h00, factor_b_q};

	// address range decode
	assign in_ram      = item.address[15:EXRAM_AW] == ADDR_EXRAM_BASE[15:EXRAM_AW];
	assign in_prg_bank = item.address[15:2] == ADDR_PRG_BANK0[15:2];
	assign in_spr_bank = item.address[15:3] == ADDR_SPR_BANK0[15:3];
	assign in_bg_bank  = item.address[15:2] == ADDR_BG_BANK0[15:2];

	// extra RAM write port, active only on a committing write
	assign ram_idx   = item.address[EXRAM_AW-1:0];
	assign ram_wdata = item.wdata;
	assign ram_we    = commit && item.action == ACT_WRITE && in_ram
		&& xram_cfg_q != XRAM_CFG_RO;

	// next state and result for the item in the input register
	always_comb begin
		prg_layout_d  = prg_layout_q;
		chr_layout_d  = chr_layout_q;
		chr_upper_d   = chr_upper_q;
		xram_cfg_d    = xram_cfg_q;
		prg_bank_d    = prg_bank_q;
		spr_bank_d    = spr_bank_q;
		bg_bank_d     = bg_bank_q;
		factor_a_d    = factor_a_q;
		factor_b_d    = factor_b_q;
		line_cnt_d    = line_cnt_q;
		line_reload_d = line_reload_q;
		irq_en_d      = irq_en_q;
		irq_wait_d    = irq_wait_q;
		prg_mapped_d  = prg_mapped_q;
		result.read_data  = 8'h00;
		result.irq_pulse  = 1'b0;
		result.rom_offset = 23'd0;
		case (item.action)
			ACT_WRITE: begin
				if (in_ram) begin
					// handled on the RAM write port
				end else if (in_prg_bank) begin
					prg_bank_d[item.address[1:0]] = item.wdata;
					prg_mapped_d = 1'b1;
				end else if (in_spr_bank) begin
					spr_bank_d[item.address[2:0]] = {chr_upper_q, item.wdata};
				end else if (in_bg_bank) begin
					bg_bank_d[item.address[1:0]] = {chr_upper_q, item.wdata};
				end else begin
					case (item.address)
						ADDR_PRG_LAYOUT: begin
							prg_layout_d = item.wdata[1:0];
							prg_mapped_d = 1'b1;
						end
						ADDR_CHR_LAYOUT: chr_layout_d = item.wdata[1:0];
						ADDR_XRAM_CFG:   xram_cfg_d   = item.wdata[1:0];
						ADDR_CHR_UPPER:  chr_upper_d  = item.wdata[1:0];
						ADDR_IRQ_LINE: begin
							line_reload_d = item.wdata;
							line_cnt_d    = item.wdata;
							irq_wait_d    = 1'b0;
						end
						ADDR_IRQ_STATUS: begin
							irq_en_d   = item.wdata[7];
							irq_wait_d = 1'b0;
						end
						ADDR_MUL_LO: factor_a_d = item.wdata;
						ADDR_MUL_HI: factor_b_d = item.wdata;
						default: ;
					endcase
				end
			end
			ACT_READ: begin
				if (in_ram) begin
					result.read_data = ram_rdata;
				end else begin
					case (item.address)
						ADDR_IRQ_STATUS: begin
							result.read_data = {1'b0, irq_wait_q, 6'b000000};
							irq_wait_d = 1'b0;
						end
						ADDR_MUL_LO: result.read_data = product[7:0];
						ADDR_MUL_HI: result.read_data = product[15:8];
						default:     result.read_data = UNMAPPED_BYTE;
					endcase
				end
			end
			ACT_TICK: begin
				if (irq_en_q) begin
					if (line_cnt_q == 8'd0) begin
						irq_wait_d       = 1'b1;
						result.irq_pulse = 1'b1;
						line_cnt_d       = line_reload_q;
					end else begin
						line_cnt_d = line_cnt_q - 8'd1;
					end
				end
			end
			ACT_PRG: result.rom_offset = prg_offset;
			ACT_CHR: result.rom_offset = chr_offset;
			default: ;
		endcase
		result.irq_flag = irq_wait_d;
	end

	// commit state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_layout_q  <= PRG_LAYOUT_8K;
			chr_layout_q  <= CHR_LAYOUT_1K;
			chr_upper_q   <= '0;
			xram_cfg_q    <= '0;
			prg_bank_q    <= '0;
			spr_bank_q    <= '0;
			bg_bank_q     <= '0;
			factor_a_q    <= '0;
			factor_b_q    <= '0;
			line_cnt_q    <= '0;
			line_reload_q <= '0;
			irq_en_q      <= 1'b0;
			irq_wait_q    <= 1'b0;
			prg_mapped_q  <= 1'b0;
		end else if (commit) begin
			prg_layout_q  <= prg_layout_d;
			chr_layout_q  <= chr_layout_d;
			chr_upper_q   <= chr_upper_d;
			xram_cfg_q    <= xram_cfg_d;
			prg_bank_q    <= prg_bank_d;
			spr_bank_q    <= spr_bank_d;
			bg_bank_q     <= bg_bank_d;
			factor_a_q    <= factor_a_d;
			factor_b_q    <= factor_b_d;
			line_cnt_q    <= line_cnt_d;
			line_reload_q <= line_reload_d;
			irq_en_q      <= irq_en_d;
			irq_wait_q    <= irq_wait_d;
			prg_mapped_q  <= prg_mapped_d;
		end
	end

endmodule

### design/cartridge_bank_mapper_with_irq.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_irq
// Bank mapper with scanline IRQ counter, multiplier and 1 KiB extra RAM.
// Timing: an input transaction passes through the input register, then the
//   result register; the extra RAM read is issued on the input edge.
// Throughput: one item per cycle while m_tready is high and the RAM is not clearing.
// Reset: valid flags and mapper registers take their reset values at once;
//   the extra RAM is then cleared one entry per cycle, with s_tready low.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_with_irq import cbm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // address[15:0], write_data[23:16]
	input  logic [2:0]  s_tuser,   // action[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // read_data[7:0], irq_pulse[8], irq_flag[9],
	                               // rom_offset[32:10], zero[39:33]
);

	cbm_item_t   item_s1;
	logic        valid_s1;
	cbm_result_t result;
	cbm_result_t result_s2;
	logic        valid_s2;
	logic        adv_s1, accept, ram_busy, ram_we;
	logic [EXRAM_AW-1:0] ram_idx;
	logic [7:0]  ram_wdata, ram_rdata;

	// handshake: the input register drains whenever the result register frees
	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !ram_busy && (!valid_s1 || adv_s1);
	assign accept   = s_tvalid && s_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.action  <= cbm_action_t'(s_tuser);
			item_s1.address <= s_tdata[15:0];
			item_s1.wdata   <= s_tdata[23:16];
		end
	end

	cbm_exram u_exram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_idx  (s_tdata[EXRAM_AW-1:0]),
		.wr_en   (ram_we),
		.wr_idx  (ram_idx),
		.wr_data (ram_wdata),
		.rd_data (ram_rdata),
		.busy    (ram_busy)
	);

	cbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (adv_s1),
		.item      (item_s1),
		.ram_rdata (ram_rdata),
		.ram_we    (ram_we),
		.ram_idx   (ram_idx),
		.ram_wdata (ram_wdata),
		.result    (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, result_s2.rom_offset, result_s2.irq_flag,
		result_s2.irq_pulse, result_s2.read_data};

	// no transaction is taken while the RAM sweep runs
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_busy |-> !s_tready)
		else $error("input accepted during RAM clear");

	// a raised interrupt is always reported as pending
	a_pulse_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[8]) |-> m_tdata[9])
		else $error("irq pulse without pending flag");

	// a stalled result keeps the queued item in the input register
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !m_tready) |=> (valid_s1 && $stable(item_s1)))
		else $error("input register lost item under stall");

endmodule
